// File: sv/tbsg_pkg.sv
// Shared widths, codes, reset values and the sine table of the tone burst generator.
package tbsg_pkg;

  localparam int LEN_W      = 24;
  localparam int FADE_W     = 16;
  localparam int PHASE_W    = 32;
  localparam int TONE_IDX_W = 2;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SINE_W     = 14;
  localparam int SINE_IDX_W = 5;
  localparam int DIFF_W     = 13;
  localparam int FRAC_W     = 16;
  localparam int FRAC_LSB   = PHASE_W - SINE_IDX_W - FRAC_W;
  localparam int ACC_W      = 30;
  localparam int MAG_W      = 15;
  localparam int PROD_W     = 32;
  localparam int CNT_W      = 4;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(FRAC_W - 1);
  localparam logic [CNT_W-1:0] ENV_LAST = CNT_W'(FADE_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MAG_W - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_TONE_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LENGTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE0_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE1_STEP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE2_STEP  = 3'd5;

  localparam logic [LEN_W-1:0]   RST_TONE_LENGTH = 24'd12000;
  localparam logic [LEN_W-1:0]   RST_GAP_LENGTH  = 24'd4800;
  localparam logic [FADE_W-1:0]  RST_FADE_LENGTH = 16'd240;
  localparam logic [PHASE_W-1:0] RST_TONE0_STEP  = 32'd44739242;
  localparam logic [PHASE_W-1:0] RST_TONE1_STEP  = 32'd89478485;
  localparam logic [PHASE_W-1:0] RST_TONE2_STEP  = 32'd178956970;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_PEAK = 16'sd24000;

  localparam logic signed [SINE_W-1:0] SINE_TABLE [0:31] = '{
     14'sd0,     14'sd1171,  14'sd2296,  14'sd3333,
     14'sd4243,  14'sd4989,  14'sd5543,  14'sd5885,
     14'sd6000,  14'sd5885,  14'sd5543,  14'sd4989,
     14'sd4243,  14'sd3333,  14'sd2296,  14'sd1171,
     14'sd0,    -14'sd1171, -14'sd2296, -14'sd3333,
    -14'sd4243, -14'sd4989, -14'sd5543, -14'sd5885,
    -14'sd6000, -14'sd5885, -14'sd5543, -14'sd4989,
    -14'sd4243, -14'sd3333, -14'sd2296, -14'sd1171
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_ENV,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

// File: sv/tone_burst_sine_generator.sv
// Tone burst sine generator: sequencer, bit-serial interpolation, envelope and divide.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------
//   cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//   in      | in        | in_valid / in_ready    | in_restart
//   out     | out       | out_valid / out_ready  | out_sample_value, out_finished
//
// A tone word runs from accept to next accept through the serial interpolation
// multiply, a scale step, the serial envelope multiply, the restoring divide, the
// output register load (which waits on a stalled output) and idle. With fade_length
// of zero envelope and divide are skipped. Gap and finished words skip to the load.
// Reset (synchronous, rst_n low) restores the register defaults and the sequence.
// A stalled output word holds in the output register while the next word is taken.
module tone_burst_sine_generator #(
  parameter int TONE_COUNT = 3
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tbsg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tbsg_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_restart,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [tbsg_pkg::SAMPLE_W-1:0]  out_sample_value,
  output logic                                  out_finished
);
  import tbsg_pkg::*;

  localparam logic [TONE_IDX_W-1:0] TONE_END = TONE_IDX_W'(TONE_COUNT);

  // configuration
  logic [LEN_W-1:0]   tone_length_r, gap_length_r;
  logic [FADE_W-1:0]  fade_length_r;
  logic [PHASE_W-1:0] tone0_step_r, tone1_step_r, tone2_step_r;

  // sequence
  logic [TONE_IDX_W-1:0] tone_index_r, tone_index_nxt;
  logic [LEN_W-1:0]      frame_count_r, frame_count_nxt;
  logic [PHASE_W-1:0]    phase_accum_r, phase_accum_nxt;
  logic                  gap_active_r, gap_active_nxt;

  logic [TONE_IDX_W-1:0] tone_eff;
  logic [LEN_W-1:0]      fc_eff;
  logic [PHASE_W-1:0]    ph_eff;
  logic                  gap_eff;
  logic [LEN_W:0]        fc_inc;
  logic [PHASE_W-1:0]    step_sel;
  logic                  sounding;
  logic                  finished_nxt;
  logic [LEN_W-1:0]      remaining;
  logic [LEN_W-1:0]      remaining_m1;
  logic [FADE_W-1:0]     gain_eff;
  logic [SINE_IDX_W-1:0] sine_idx;
  logic signed [SINE_W-1:0] lo_eff, hi_eff;
  logic signed [SINE_W:0]   diff_wide;

  // control
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  logic             out_load;

  // datapath
  logic signed [SINE_W-1:0]   lo_r;
  logic signed [DIFF_W-1:0]   diff_r;
  logic [FRAC_W-1:0]          frac_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    diff_ext;
  logic signed [ACC_W-1:0]    mul_sum;
  logic [FADE_W-1:0]          gain_r;
  logic                       fin_r;
  logic signed [SAMPLE_W-1:0] res_r;
  logic [PROD_W-1:0]          prod_r;
  logic signed [SINE_W-1:0]   interp;
  logic signed [SAMPLE_W-1:0] s_val;
  logic signed [SAMPLE_W-1:0] res_neg;
  logic [MAG_W-1:0]           mag;
  logic [FADE_W:0]            env_sum;
  logic [FADE_W:0]            div_try;
  logic [FADE_W:0]            div_diff;
  logic                       div_bit;
  logic [FADE_W-1:0]          div_rem;
  logic [MAG_W-1:0]           quo;
  logic signed [SAMPLE_W-1:0] quo_neg;

  // output register
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_value_r;
  logic                       out_finished_r;

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_sample_value = out_sample_value_r;
  assign out_finished     = out_finished_r;
  assign accept           = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_length_r <= RST_TONE_LENGTH;
      gap_length_r  <= RST_GAP_LENGTH;
      fade_length_r <= RST_FADE_LENGTH;
      tone0_step_r  <= RST_TONE0_STEP;
      tone1_step_r  <= RST_TONE1_STEP;
      tone2_step_r  <= RST_TONE2_STEP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TONE_LENGTH: tone_length_r <= cfg_data[LEN_W-1:0];
        CFG_GAP_LENGTH:  gap_length_r  <= cfg_data[LEN_W-1:0];
        CFG_FADE_LENGTH: fade_length_r <= cfg_data[FADE_W-1:0];
        CFG_TONE0_STEP:  tone0_step_r  <= cfg_data[PHASE_W-1:0];
        CFG_TONE1_STEP:  tone1_step_r  <= cfg_data[PHASE_W-1:0];
        CFG_TONE2_STEP:  tone2_step_r  <= cfg_data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequence advance for the word being accepted; restart clears first.
  always_comb begin
    tone_eff = in_restart ? '0 : tone_index_r;
    fc_eff   = in_restart ? '0 : frame_count_r;
    ph_eff   = in_restart ? '0 : phase_accum_r;
    gap_eff  = in_restart ? 1'b0 : gap_active_r;

    tone_index_nxt  = tone_eff;
    frame_count_nxt = fc_eff;
    phase_accum_nxt = ph_eff;
    gap_active_nxt  = gap_eff;
    sounding        = 1'b0;
    fc_inc          = {1'b0, fc_eff} + 1'b1;

    priority if (tone_eff == 2'd0) step_sel = tone0_step_r;
    else if (tone_eff == 2'd1)     step_sel = tone1_step_r;
    else                           step_sel = tone2_step_r;

    if (tone_eff < TONE_END) begin
      if (gap_eff) begin
        if (fc_inc >= {1'b0, gap_length_r}) begin
          tone_index_nxt  = tone_eff + 1'b1;
          gap_active_nxt  = 1'b0;
          frame_count_nxt = '0;
          phase_accum_nxt = '0;
        end else begin
          frame_count_nxt = fc_inc[LEN_W-1:0];
        end
      end else begin
        sounding        = 1'b1;
        phase_accum_nxt = ph_eff + step_sel;
        if (fc_inc >= {1'b0, tone_length_r}) begin
          gap_active_nxt  = 1'b1;
          frame_count_nxt = '0;
        end else begin
          frame_count_nxt = fc_inc[LEN_W-1:0];
        end
      end
    end
    finished_nxt = tone_index_nxt >= TONE_END;

    // envelope gain: ramp up, ramp down, else flat
    remaining    = tone_length_r - fc_eff;
    remaining_m1 = remaining - 1'b1;
    priority if ({{(LEN_W-FADE_W){1'b0}}, fade_length_r} > fc_eff) begin
      gain_eff = fc_eff[FADE_W-1:0];
    end else if (fc_eff < tone_length_r &&
                 remaining <= {{(LEN_W-FADE_W){1'b0}}, fade_length_r}) begin
      gain_eff = remaining_m1[FADE_W-1:0];
    end else begin
      gain_eff = fade_length_r;
    end

    sine_idx  = ph_eff[PHASE_W-1 -: SINE_IDX_W];
    lo_eff    = SINE_TABLE[sine_idx];
    hi_eff    = SINE_TABLE[sine_idx + 1'b1];
    diff_wide = {hi_eff[SINE_W-1], hi_eff} - {lo_eff[SINE_W-1], lo_eff};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_index_r  <= '0;
      frame_count_r <= '0;
      phase_accum_r <= '0;
      gap_active_r  <= 1'b0;
    end else if (accept) begin
      tone_index_r  <= tone_index_nxt;
      frame_count_r <= frame_count_nxt;
      phase_accum_r <= phase_accum_nxt;
      gap_active_r  <= gap_active_nxt;
    end
  end

  // Serial datapath arithmetic.
  always_comb begin
    diff_ext = {{(ACC_W-DIFF_W-FRAC_W){diff_r[DIFF_W-1]}}, diff_r, {FRAC_W{1'b0}}};
    mul_sum  = acc_r + (frac_r[0] ? diff_ext : '0);
    // upper bits of the full product give the floor of the 16-bit shift
    interp   = lo_r + acc_r[FRAC_W +: SINE_W];
    s_val    = {interp, 2'b00};
    res_neg  = -res_r;
    mag      = res_r[SAMPLE_W-1] ? res_neg[MAG_W-1:0] : res_r[MAG_W-1:0];
    env_sum  = {1'b0, prod_r[PROD_W-1:FADE_W]} +
               (prod_r[0] ? {{(FADE_W+1-MAG_W){1'b0}}, mag} : '0);
    // restoring divide: partial remainder sits above the unconsumed dividend bits
    div_try  = prod_r[PROD_W-2:MAG_W-1];
    div_diff = div_try - {1'b0, fade_length_r};
    div_bit  = div_try >= {1'b0, fade_length_r};
    div_rem  = div_bit ? div_diff[FADE_W-1:0] : div_try[FADE_W-1:0];
    quo      = {prod_r[MAG_W-2:0], div_bit};
    quo_neg  = -$signed({1'b0, quo});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cnt_nxt   = '0;
          state_nxt = sounding ? ST_MUL : ST_FIN;
        end
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MUL_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_nxt = (fade_length_r == '0) ? ST_FIN : ST_ENV;
      end
      ST_ENV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ENV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          lo_r   <= lo_eff;
          diff_r <= diff_wide[DIFF_W-1:0];
          frac_r <= ph_eff[FRAC_LSB +: FRAC_W];
          acc_r  <= '0;
          gain_r <= gain_eff;
          fin_r  <= finished_nxt;
          res_r  <= '0;
        end
      end
      ST_MUL: begin
        // shift-right multiply; floor shift falls out of the arithmetic shifts
        acc_r  <= mul_sum >>> 1;
        frac_r <= frac_r >> 1;
      end
      ST_SCALE: begin
        res_r  <= s_val;
        prod_r <= {{(PROD_W-FADE_W){1'b0}}, gain_r};
      end
      ST_ENV: begin
        prod_r <= {env_sum, prod_r[FADE_W-1:1]};
      end
      ST_DIV: begin
        prod_r <= {1'b0, div_rem, prod_r[MAG_W-2:0], div_bit};
        if (cnt_r == DIV_LAST) begin
          res_r <= res_r[SAMPLE_W-1] ? quo_neg : $signed({1'b0, quo});
        end
      end
      ST_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_value_r <= res_r;
      out_finished_r     <= fin_r;
    end
  end

`ifndef SYNTHESIS
  a_finished_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_finished) |-> (out_sample_value == '0))
    else $error("finished word carries a nonzero sample");

  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample_value <= SAMPLE_PEAK && out_sample_value >= -SAMPLE_PEAK))
    else $error("sample outside full scale");

  a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (prod_r[PROD_W-2:MAG_W] < fade_length_r))
    else $error("divider partial remainder not below fade length");

  a_tone_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (tone_index_r <= TONE_END))
    else $error("tone index past the last tone");
`endif

endmodule
